FILE: rtl/lpr_pkg.sv
// shared types and constants of the line pixel rasterizer
// no dependencies; compiled before every other file of the block
package lpr_pkg;

  localparam int DATA_W = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] start_x;
    logic [DATA_W-1:0] start_y;
    logic [DATA_W-1:0] end_x;
    logic [DATA_W-1:0] end_y;
    logic [DATA_W-1:0] line_color;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] pixel_x;
    logic [DATA_W-1:0] pixel_y;
    logic [DATA_W-1:0] pixel_color;
    logic              last_pixel;
  } pixel_t;

endpackage

FILE: rtl/lpr_cmd_if.sv
// command channel of the line pixel rasterizer: load and step transactions
// depends on lpr_pkg for the field widths and the op code type
interface lpr_cmd_if;
  logic                      valid;
  logic                      ready;
  lpr_pkg::op_t              op;
  logic [lpr_pkg::DATA_W-1:0] start_x;
  logic [lpr_pkg::DATA_W-1:0] start_y;
  logic [lpr_pkg::DATA_W-1:0] end_x;
  logic [lpr_pkg::DATA_W-1:0] end_y;
  logic [lpr_pkg::DATA_W-1:0] line_color;

  modport source (output valid, op, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, op, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

FILE: rtl/lpr_pix_if.sv
// pixel channel of the line pixel rasterizer: one pixel per transaction
// depends on lpr_pkg for the field widths
interface lpr_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lpr_pkg::DATA_W-1:0] pixel_x;
  logic [lpr_pkg::DATA_W-1:0] pixel_y;
  logic [lpr_pkg::DATA_W-1:0] pixel_color;
  logic                       last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface

FILE: rtl/line_pixel_rasterizer_core.sv
// line pixel rasterizer: command decode, line engine and pixel output buffer
// depends on lpr_pkg, lpr_cmd_if, lpr_pix_if, lpr_engine, lpr_out_buf
//
// usage
//   cmd channel: a load transaction (op = load) latches both end points and
//   the colour and gives no pixel; a step transaction (op = step) gives the
//   next pixel of the running line, or nothing when no line is running
//   a load during a running line drops it and starts the new one
//   pix channel: one transaction per pixel, last_pixel marks the final one;
//   a line from one end point to the other gives max(|dx|, |dy|) + 1 pixels
//   a pixel is offered from the output register, not straight from its step transaction
//   throughput: one command per cycle while the skid entry is free; the error
//   accumulators update combinationally (one add and compare per axis)
//   stall: a held pixel waits in the output register, one more pixel fits in
//   the skid entry; cmd.ready drops only while the skid entry is full
//   reset: synchronous, clears the running flag and empties both buffers
//   COORD_BITS: coordinates are kept modulo 2^COORD_BITS (8 to 16)
module line_pixel_rasterizer_core #(
  parameter int COORD_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  lpr_cmd_if.sink   cmd,
  lpr_pix_if.source pix
);
  import lpr_pkg::*;

  cmd_t   cmd_data;
  pixel_t res, out_data;
  logic   accept, res_valid, buf_ready;

  // a transaction is taken whenever the skid entry is free
  assign cmd.ready = buf_ready;
  assign accept    = cmd.valid && buf_ready;

  assign cmd_data.op         = cmd.op;
  assign cmd_data.start_x    = cmd.start_x;
  assign cmd_data.start_y    = cmd.start_y;
  assign cmd_data.end_x      = cmd.end_x;
  assign cmd_data.end_y      = cmd.end_y;
  assign cmd_data.line_color = cmd.line_color;

  // line state, updated in the cycle the command is taken
  lpr_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd_data),
    .res_valid(res_valid),
    .res      (res)
  );

  // registered pixel output, decouples the receiver from the command side
  lpr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .push_ready(buf_ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .out_data  (out_data)
  );

  assign pix.pixel_x     = out_data.pixel_x;
  assign pix.pixel_y     = out_data.pixel_y;
  assign pix.pixel_color = out_data.pixel_color;
  assign pix.last_pixel  = out_data.last_pixel;

endmodule

FILE: rtl/lpr_engine.sv
// line state and per-pixel error accumulation of the rasterizer
// depends on lpr_pkg (cmd_t, pixel_t, op_t, dir_t)
module lpr_engine #(
  parameter int COORD_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  lpr_pkg::cmd_t   cmd,
  output logic            res_valid,
  output lpr_pkg::pixel_t res
);
  import lpr_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0]      cur_x, cur_y, abs_dx, abs_dy, span;
  logic [C:0]        err_x, err_y, pixel_count;
  dir_t              dir_x, dir_y;
  logic [DATA_W-1:0] held_color;
  logic              active;

  logic [C-1:0]      cur_x_next, cur_y_next, abs_dx_next, abs_dy_next, span_next;
  logic [C:0]        err_x_next, err_y_next, pixel_count_next;
  dir_t              dir_x_next, dir_y_next;
  logic [DATA_W-1:0] held_color_next;
  logic              active_next;

  logic [C-1:0] sx, sy, ex, ey;
  logic [C:0]   sum_x, sum_y;

  function automatic logic [C-1:0] axis_move(input logic [C-1:0] pos, input dir_t dir);
    logic [C-1:0] moved;
    moved = pos;
    if (dir == DIR_PLUS) begin
      moved = pos + 1'b1;
    end else if (dir == DIR_MINUS) begin
      moved = pos - 1'b1;
    end
    return moved;
  endfunction

  always_comb begin
    sx = cmd.start_x[C-1:0];
    sy = cmd.start_y[C-1:0];
    ex = cmd.end_x[C-1:0];
    ey = cmd.end_y[C-1:0];
    sum_x = err_x + {1'b0, abs_dx};
    sum_y = err_y + {1'b0, abs_dy};

    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    abs_dx_next      = abs_dx;
    abs_dy_next      = abs_dy;
    span_next        = span;
    err_x_next       = err_x;
    err_y_next       = err_y;
    dir_x_next       = dir_x;
    dir_y_next       = dir_y;
    pixel_count_next = pixel_count;
    held_color_next  = held_color;
    active_next      = active;
    res_valid        = 1'b0;

    res.pixel_x     = DATA_W'(cur_x);
    res.pixel_y     = DATA_W'(cur_y);
    res.pixel_color = held_color;
    res.last_pixel  = (pixel_count == (C+1)'(1));

    if (accept) begin
      case (cmd.op)
        OP_LOAD: begin
          if (ex > sx) begin
            abs_dx_next = ex - sx;
            dir_x_next  = DIR_PLUS;
          end else if (ex < sx) begin
            abs_dx_next = sx - ex;
            dir_x_next  = DIR_MINUS;
          end else begin
            abs_dx_next = '0;
            dir_x_next  = DIR_NONE;
          end
          if (ey > sy) begin
            abs_dy_next = ey - sy;
            dir_y_next  = DIR_PLUS;
          end else if (ey < sy) begin
            abs_dy_next = sy - ey;
            dir_y_next  = DIR_MINUS;
          end else begin
            abs_dy_next = '0;
            dir_y_next  = DIR_NONE;
          end
          span_next        = (abs_dx_next > abs_dy_next) ? abs_dx_next : abs_dy_next;
          cur_x_next       = sx;
          cur_y_next       = sy;
          err_x_next       = '0;
          err_y_next       = '0;
          pixel_count_next = {1'b0, span_next} + 1'b1;
          held_color_next  = cmd.line_color;
          active_next      = 1'b1;
        end
        OP_STEP: begin
          if (active) begin
            res_valid  = 1'b1;
            err_x_next = sum_x;
            err_y_next = sum_y;
            if (sum_x > {1'b0, span}) begin
              err_x_next = sum_x - {1'b0, span};
              cur_x_next = axis_move(cur_x, dir_x);
            end
            if (sum_y > {1'b0, span}) begin
              err_y_next = sum_y - {1'b0, span};
              cur_y_next = axis_move(cur_y, dir_y);
            end
            // count is never zero while a line is running
            pixel_count_next = pixel_count - 1'b1;
            active_next      = (pixel_count != (C+1)'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixel_count <= '0;
      dir_x       <= DIR_NONE;
      dir_y       <= DIR_NONE;
    end else begin
      active      <= active_next;
      pixel_count <= pixel_count_next;
      dir_x       <= dir_x_next;
      dir_y       <= dir_y_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    abs_dx     <= abs_dx_next;
    abs_dy     <= abs_dy_next;
    span       <= span_next;
    err_x      <= err_x_next;
    err_y      <= err_y_next;
    held_color <= held_color_next;
  end

endmodule

FILE: rtl/lpr_out_buf.sv
// pixel output register with one skid entry behind it
// depends on lpr_pkg (pixel_t)
module lpr_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpr_pkg::pixel_t push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lpr_pkg::pixel_t out_data
);
  import lpr_pkg::*;

  logic   main_valid, skid_valid;
  pixel_t main_data, skid_data;
  logic   drain;

  assign drain      = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

FILE: sim/line_pixel_rasterizer_core_tb.sv
// testbench of line_pixel_rasterizer_core: loads and steps lines, predicts every pixel
// depends on lpr_pkg, lpr_cmd_if, lpr_pix_if and the rasterizer rtl
module line_pixel_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpr_pkg::*;

  localparam int COORD_BITS = 16;
  localparam logic [DATA_W-1:0] COORD_MASK = DATA_W'((32'd1 << COORD_BITS) - 1);
  localparam int HOLD_CYCLES = 400;

  bit clk = 1'b0;
  bit rst = 1'b1;

  lpr_cmd_if cmd_bus();
  lpr_pix_if pix_bus();

  line_pixel_rasterizer_core #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .pix (pix_bus)
  );

  always #5 clk = ~clk;

  // commands waiting to be driven and pixels waiting to come out
  cmd_t   cmd_pending[$];
  pixel_t pixel_expect[$];

  int  mismatches = 0;
  bit  quiet_tail = 1'b0;   // no idling on either side once set
  bit  long_hold_go = 1'b0;
  bit  hold_pix = 1'b0;
  int  src_gap = 0;
  int  sink_gap = 0;

  // line state of the predictor
  logic [DATA_W-1:0] ln_x = '0, ln_y = '0, ln_dx = '0, ln_dy = '0;
  logic [DATA_W-1:0] ln_span = '0, ln_color = '0;
  logic [DATA_W:0]   acc_x = '0, acc_y = '0, pix_left = '0;
  dir_t              dir_x = DIR_NONE, dir_y = DIR_NONE;
  bit                ln_busy = 1'b0;

  function automatic logic [DATA_W-1:0] nudge(logic [DATA_W-1:0] pos, dir_t d);
    case (d)
      DIR_PLUS:  return (pos + 1'b1) & COORD_MASK;
      DIR_MINUS: return (pos - 1'b1) & COORD_MASK;
      default:   return pos;
    endcase
  endfunction

  task automatic axis_setup(input logic [DATA_W-1:0] from, input logic [DATA_W-1:0] to,
                            output logic [DATA_W-1:0] mag, output dir_t d);
    if (to > from) begin
      mag = to - from;
      d = DIR_PLUS;
    end else if (to < from) begin
      mag = from - to;
      d = DIR_MINUS;
    end else begin
      mag = '0;
      d = DIR_NONE;
    end
  endtask

  // advance the predicted line by one accepted command
  task automatic rasterize(input cmd_t c);
    logic [DATA_W-1:0] sx, sy;
    pixel_t px;
    if (c.op == OP_LOAD) begin
      sx = c.start_x & COORD_MASK;
      sy = c.start_y & COORD_MASK;
      axis_setup(sx, c.end_x & COORD_MASK, ln_dx, dir_x);
      axis_setup(sy, c.end_y & COORD_MASK, ln_dy, dir_y);
      ln_span = (ln_dx > ln_dy) ? ln_dx : ln_dy;
      ln_x = sx;
      ln_y = sy;
      acc_x = '0;
      acc_y = '0;
      pix_left = {1'b0, ln_span} + 1'b1;
      ln_color = c.line_color;
      ln_busy = 1'b1;
    end else if (ln_busy) begin
      px.pixel_x = ln_x;
      px.pixel_y = ln_y;
      px.pixel_color = ln_color;
      px.last_pixel = (pix_left == 1);
      pixel_expect.push_back(px);
      acc_x = acc_x + {1'b0, ln_dx};
      acc_y = acc_y + {1'b0, ln_dy};
      if (acc_x > {1'b0, ln_span}) begin
        acc_x = acc_x - {1'b0, ln_span};
        ln_x = nudge(ln_x, dir_x);
      end
      if (acc_y > {1'b0, ln_span}) begin
        acc_y = acc_y - {1'b0, ln_span};
        ln_y = nudge(ln_y, dir_y);
      end
      if (pix_left != 0) pix_left = pix_left - 1'b1;
      if (pix_left == 0) ln_busy = 1'b0;
    end
  endtask

  // driver: predicts on each accepted transaction, then offers the next command
  always @(posedge clk) begin
    cmd_t seen, nxt;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        seen.op = cmd_bus.op;
        seen.start_x = cmd_bus.start_x;
        seen.start_y = cmd_bus.start_y;
        seen.end_x = cmd_bus.end_x;
        seen.end_y = cmd_bus.end_y;
        seen.line_color = cmd_bus.line_color;
        rasterize(seen);
        void'(cmd_pending.pop_front());
        if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 12);
      end
      if (src_gap > 0) begin
        src_gap--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        nxt = cmd_pending[0];
        cmd_bus.valid <= 1'b1;
        cmd_bus.op <= nxt.op;
        cmd_bus.start_x <= nxt.start_x;
        cmd_bus.start_y <= nxt.start_y;
        cmd_bus.end_x <= nxt.end_x;
        cmd_bus.end_y <= nxt.end_y;
        cmd_bus.line_color <= nxt.line_color;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: checks each pixel transaction against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pix_bus.ready <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixel_expect.size() == 0) begin
          $error("pixel with nothing expected: x %0d y %0d", pix_bus.pixel_x, pix_bus.pixel_y);
          mismatches++;
        end else begin
          want = pixel_expect.pop_front();
          check_field("pixel_x", want.pixel_x, pix_bus.pixel_x);
          check_field("pixel_y", want.pixel_y, pix_bus.pixel_y);
          check_field("pixel_color", want.pixel_color, pix_bus.pixel_color);
          check_field("last_pixel", want.last_pixel, pix_bus.last_pixel);
        end
      end
      if (hold_pix) begin
        pix_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        pix_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 11);
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= 1'b1;
      end
    end
  end

  // long receiver stall: the skid fills and cmd.ready must drop
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    hold_pix <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pix <= 1'b0;
  end

  task automatic push_load(input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
                           input logic [DATA_W-1:0] ex, input logic [DATA_W-1:0] ey,
                           input logic [DATA_W-1:0] color);
    cmd_t c;
    c.op = OP_LOAD;
    c.start_x = sx;
    c.start_y = sy;
    c.end_x = ex;
    c.end_y = ey;
    c.line_color = color;
    cmd_pending.push_back(c);
  endtask

  // step transactions carry junk in the unused fields
  task automatic push_steps(input int n);
    cmd_t c;
    repeat (n) begin
      c.op = OP_STEP;
      c.start_x = DATA_W'($urandom);
      c.start_y = DATA_W'($urandom);
      c.end_x = DATA_W'($urandom);
      c.end_y = DATA_W'($urandom);
      c.line_color = DATA_W'($urandom);
      cmd_pending.push_back(c);
    end
  endtask

  function automatic int absdiff(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  // one random line: short lines mostly walked to the end, long ones cut off by the next load
  task automatic queue_line(input bit far_ends, output int n_items);
    logic [DATA_W-1:0] sx, sy, ex, ey;
    int span_len, k;
    sx = DATA_W'($urandom);
    sy = DATA_W'($urandom);
    if (far_ends) begin
      ex = DATA_W'($urandom);
      ey = DATA_W'($urandom);
    end else begin
      ex = sx + DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
      ey = sy + DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
    end
    span_len = (absdiff(sx, ex) > absdiff(sy, ey)) ? absdiff(sx, ex) : absdiff(sy, ey);
    k = span_len + 1;
    if (k > 48) k = $urandom_range(1, 12);
    else if ($urandom_range(0, 5) == 0) k = $urandom_range(1, k);
    push_load(sx, sy, ex, ey, DATA_W'($urandom));
    push_steps(k);
    n_items = k + 1;
    // a few steps after the line is done give nothing
    if (k == span_len + 1 && $urandom_range(0, 3) == 0) push_steps($urandom_range(1, 2));
  endtask

  // sender pause: nothing new until every predicted pixel is out
  task automatic settle();
    wait (cmd_pending.size() == 0);
    wait (pixel_expect.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int sent, n, last_pause;
    bit hold_done;
    cmd_t junk;
    sent = 0;
    last_pause = 0;
    hold_done = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.op = OP_LOAD;
    cmd_bus.start_x = '0;
    cmd_bus.start_y = '0;
    cmd_bus.end_x = '0;
    cmd_bus.end_y = '0;
    cmd_bus.line_color = '0;
    pix_bus.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // step with no line running
    push_steps(1);
    // single points at both corners, then a step past the end
    push_load('0, '0, '0, '0, '0);
    push_steps(2);
    push_load('1, '1, '1, '1, '1);
    push_steps(1);
    // shallow line, both axes up
    push_load(16'd0, 16'd0, 16'd3, 16'd1, 16'hA5A5);
    push_steps(4);
    // steep line, x down, cut off by a load while busy
    push_load(16'd10, 16'd10, 16'd8, 16'd14, 16'h5A5A);
    push_steps(2);
    // horizontal line going left from the top column
    push_load(16'hFFFF, 16'd0, 16'hFFFA, 16'd0, 16'h1234);
    push_steps(6);
    // vertical line, y going down
    push_load(16'd0, 16'hFFFF, 16'd0, 16'hFFFD, 16'hFEDC);
    push_steps(3);
    settle();

    while (sent < 1400) begin
      if (!hold_done && sent >= 600) begin
        // receiver stalls while a long line keeps the sender busy
        long_hold_go = 1'b1;
        push_load(16'd100, 16'd900, 16'd400, 16'd780, DATA_W'($urandom));
        push_steps(301);
        sent += 302;
        hold_done = 1'b1;
        settle();
        last_pause = sent;
      end
      case ($urandom_range(0, 11))
        0: begin
          queue_line(1'b1, n);
          sent += n;
        end
        1: begin
          // noise: random op and fields
          repeat ($urandom_range(1, 4)) begin
            junk.op = op_t'($urandom_range(0, 1));
            junk.start_x = DATA_W'($urandom);
            junk.start_y = DATA_W'($urandom);
            junk.end_x = DATA_W'($urandom);
            junk.end_y = DATA_W'($urandom);
            junk.line_color = DATA_W'($urandom);
            cmd_pending.push_back(junk);
          end
        end
        default: begin
          queue_line(1'b0, n);
          sent += n;
        end
      endcase
      if (sent - last_pause >= 350) begin
        settle();
        last_pause = sent;
      end
    end
    settle();

    // full 16-bit span, first few dozen pixels back to back, no idling
    quiet_tail = 1'b1;
    push_load(16'hFFFF, 16'h1234, 16'h0000, 16'h9ABC, 16'hC0DE);
    push_steps(40);
    settle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
